/* sv/iambic_keyer_with_debounce_defines.svh */
// Assertion helpers used by the top module to check itself.
`ifndef IAMBIC_KEYER_WITH_DEBOUNCE_DEFINES_SVH
`define IAMBIC_KEYER_WITH_DEBOUNCE_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define IKD_ASSERT_SAME(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the following cycle.
`define IKD_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ikd_pkg.sv */
`timescale 1ns / 1ps

package ikd_pkg;

  // Input transaction: raw active-low paddle levels for one tick.
  typedef struct packed {
    logic raw_dit_level;
    logic raw_dah_level;
  } in_t;

  // Output transaction: keyer result for one tick.
  typedef struct packed {
    logic       tone_on;
    logic       dit_pressed;
    logic       dah_pressed;
    logic [1:0] event_kind;
    logic [5:0] code_pattern;
    logic [2:0] code_length;
  } out_t;

  // Configuration register set.
  typedef struct packed {
    logic [9:0]  dit_ticks;
    logic [11:0] dah_ticks;
    logic [9:0]  element_gap_ticks;
    logic [11:0] letter_gap_ticks;
    logic [12:0] word_gap_ticks;
    logic [6:0]  press_threshold;
    logic        keyer_enable;
  } cfg_t;

  // Event codes.
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_LETTER = 2'd1;
  localparam logic [1:0] EV_WORD   = 2'd2;

  // Number of pattern bits kept for a letter.
  localparam int unsigned PATTERN_BITS = 6;
  // Width used to compare element counts against pattern bit positions.
  localparam int unsigned CNT_EXT_W = 4;

  // Start-up delay before the keyer looks at the paddles.
  localparam logic [12:0] STARTUP_BUSY = 13'd100;

  // Register reset values.
  localparam logic [9:0]  RST_DIT_TICKS   = 10'd60;
  localparam logic [11:0] RST_DAH_TICKS   = 12'd180;
  localparam logic [9:0]  RST_ELEM_GAP    = 10'd60;
  localparam logic [11:0] RST_LETTER_GAP  = 12'd120;
  localparam logic [12:0] RST_WORD_GAP    = 13'd360;
  localparam logic [6:0]  RST_THRESHOLD   = 7'd8;
  localparam logic        RST_KEYER_EN    = 1'b1;

endpackage

/* sv/ikd_regs.sv */
`timescale 1ns / 1ps

module ikd_regs
  import ikd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  // Register word indexes.
  localparam logic [2:0] IDX_DIT_TICKS  = 3'd0;
  localparam logic [2:0] IDX_DAH_TICKS  = 3'd1;
  localparam logic [2:0] IDX_ELEM_GAP   = 3'd2;
  localparam logic [2:0] IDX_LETTER_GAP = 3'd3;
  localparam logic [2:0] IDX_WORD_GAP   = 3'd4;
  localparam logic [2:0] IDX_THRESHOLD  = 3'd5;
  localparam logic [2:0] IDX_KEYER_EN   = 3'd6;

  logic [2:0] word_idx;
  logic       wr_en;

  assign word_idx = paddr[4:2];
  assign wr_en    = psel && penable && pwrite;
  assign pready   = 1'b1;

  // Register writes, masked to each register's width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dit_ticks         <= RST_DIT_TICKS;
      cfg.dah_ticks         <= RST_DAH_TICKS;
      cfg.element_gap_ticks <= RST_ELEM_GAP;
      cfg.letter_gap_ticks  <= RST_LETTER_GAP;
      cfg.word_gap_ticks    <= RST_WORD_GAP;
      cfg.press_threshold   <= RST_THRESHOLD;
      cfg.keyer_enable      <= RST_KEYER_EN;
    end else if (wr_en) begin
      unique case (word_idx)
        IDX_DIT_TICKS:  cfg.dit_ticks         <= pwdata[9:0];
        IDX_DAH_TICKS:  cfg.dah_ticks         <= pwdata[11:0];
        IDX_ELEM_GAP:   cfg.element_gap_ticks <= pwdata[9:0];
        IDX_LETTER_GAP: cfg.letter_gap_ticks  <= pwdata[11:0];
        IDX_WORD_GAP:   cfg.word_gap_ticks    <= pwdata[12:0];
        IDX_THRESHOLD:  cfg.press_threshold   <= pwdata[6:0];
        IDX_KEYER_EN:   cfg.keyer_enable      <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (word_idx)
      IDX_DIT_TICKS:  prdata = 32'(cfg.dit_ticks);
      IDX_DAH_TICKS:  prdata = 32'(cfg.dah_ticks);
      IDX_ELEM_GAP:   prdata = 32'(cfg.element_gap_ticks);
      IDX_LETTER_GAP: prdata = 32'(cfg.letter_gap_ticks);
      IDX_WORD_GAP:   prdata = 32'(cfg.word_gap_ticks);
      IDX_THRESHOLD:  prdata = 32'(cfg.press_threshold);
      IDX_KEYER_EN:   prdata = 32'(cfg.keyer_enable);
      default:        prdata = 32'd0;
    endcase
  end

endmodule

/* sv/ikd_filter.sv */
`timescale 1ns / 1ps

module ikd_filter
  import ikd_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       raw_level,
  input  logic [6:0] threshold,
  output logic       pressed
);

  localparam int unsigned SUM_W = $clog2(WINDOW_LEN + 1);

  logic [WINDOW_LEN-1:0] window;
  logic [SUM_W-1:0]      window_sum;
  logic [SUM_W-1:0]      sum_next;

  // Sliding sum: the sample leaving the window drops out, the new one enters.
  assign sum_next = window_sum - SUM_W'(window[WINDOW_LEN-1]) + SUM_W'(raw_level);
  assign pressed  = 7'(sum_next) < threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= '0;
      window_sum <= '0;
    end else if (step) begin
      window     <= {window[WINDOW_LEN-2:0], raw_level};
      window_sum <= sum_next;
    end
  end

endmodule

/* sv/ikd_keyer.sv */
`timescale 1ns / 1ps

module ikd_keyer
  import ikd_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 6
) (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  cfg_t cfg,
  input  logic dit_pressed,
  input  logic dah_pressed,
  output out_t result
);

  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);

  // Keyer state.
  logic             next_is_dah, next_is_dah_next;
  logic [11:0]      tone_left, tone_left_next;
  logic [12:0]      busy_left, busy_left_next;
  logic [11:0]      letter_left, letter_left_next;
  logic [12:0]      word_left, word_left_next;
  logic             word_done, word_done_next;
  logic [5:0]       elements_held, elements_held_next;
  logic [CNT_W-1:0] elements_count, elements_count_next;
  logic             tone_state, tone_state_next;

  // Element start terms.
  logic             start;
  logic             is_dah;
  logic [CNT_W-1:0] cnt_base;
  logic [5:0]       held_base;
  logic [5:0]       held_set;
  logic [11:0]      tone_len;
  logic [12:0]      busy_s;
  logic [11:0]      tone_s;
  logic [11:0]      letter_s;
  logic [5:0]       held_s;
  logic [CNT_W-1:0] cnt_s;
  logic [1:0]       kind;
  logic [5:0]       pat;
  logic [2:0]       len;

  // Element selection and the letter buffer update at element start.
  always_comb begin
    start    = (busy_left == 13'd0) && (dit_pressed || dah_pressed);
    is_dah   = (dit_pressed && dah_pressed) ? next_is_dah : dah_pressed;
    if (elements_count >= CNT_W'(MAX_ELEMENTS)) begin
      cnt_base  = '0;
      held_base = '0;
    end else begin
      cnt_base  = elements_count;
      held_base = elements_held;
    end
    for (int i = 0; i < PATTERN_BITS; i++) begin
      held_set[i] = is_dah && (CNT_EXT_W'(cnt_base) == CNT_EXT_W'(i));
    end
    tone_len = is_dah ? cfg.dah_ticks : 12'(cfg.dit_ticks);

    if (start) begin
      tone_s   = tone_len;
      held_s   = held_base | held_set;
      cnt_s    = cnt_base + CNT_W'(1);
      letter_s = cfg.letter_gap_ticks;
      busy_s   = 13'(cfg.element_gap_ticks) + 13'(tone_len);
    end else begin
      tone_s   = tone_left;
      held_s   = elements_held;
      cnt_s    = elements_count;
      letter_s = letter_left;
      busy_s   = busy_left;
    end

    if (busy_left != 13'd0) begin
      next_is_dah_next = next_is_dah;
    end else if (dit_pressed && dah_pressed) begin
      next_is_dah_next = !next_is_dah;
    end else if (dit_pressed) begin
      next_is_dah_next = 1'b1;
    end else if (dah_pressed) begin
      next_is_dah_next = 1'b0;
    end else begin
      next_is_dah_next = next_is_dah;
    end
  end

  // Timers and letter/word events, using the values after any start.
  always_comb begin
    busy_left_next      = busy_s;
    tone_left_next      = tone_s;
    tone_state_next     = tone_state;
    letter_left_next    = letter_s;
    elements_held_next  = held_s;
    elements_count_next = cnt_s;
    word_left_next      = word_left;
    word_done_next      = word_done;
    kind                = EV_NONE;
    pat                 = '0;
    len                 = '0;
    if (busy_s != 13'd0) begin
      busy_left_next = busy_s - 13'd1;
      if (tone_s != 12'd0) begin
        tone_state_next = 1'b1;
        tone_left_next  = tone_s - 12'd1;
      end else begin
        tone_state_next = 1'b0;
      end
    end else if (letter_s != 12'd0) begin
      letter_left_next = letter_s - 12'd1;
    end else if (cnt_s != '0) begin
      kind                = EV_LETTER;
      pat                 = held_s;
      len                 = 3'(cnt_s);
      elements_held_next  = '0;
      elements_count_next = '0;
      word_left_next      = cfg.word_gap_ticks;
      word_done_next      = 1'b0;
    end else if (word_left != 13'd0) begin
      word_left_next = word_left - 13'd1;
    end else if (!word_done) begin
      kind           = EV_WORD;
      word_done_next = 1'b1;
    end
  end

  // Result of this tick; a disabled keyer holds the tone and reports nothing.
  always_comb begin
    result.dit_pressed = dit_pressed;
    result.dah_pressed = dah_pressed;
    if (cfg.keyer_enable) begin
      result.tone_on      = tone_state_next;
      result.event_kind   = kind;
      result.code_pattern = pat;
      result.code_length  = len;
    end else begin
      result.tone_on      = tone_state;
      result.event_kind   = EV_NONE;
      result.code_pattern = '0;
      result.code_length  = '0;
    end
  end

  // State registers advance once per accepted tick while enabled.
  always_ff @(posedge clk) begin
    if (rst) begin
      next_is_dah    <= 1'b0;
      tone_left      <= '0;
      busy_left      <= STARTUP_BUSY;
      letter_left    <= '0;
      word_left      <= '0;
      word_done      <= 1'b0;
      elements_held  <= '0;
      elements_count <= '0;
      tone_state     <= 1'b0;
    end else if (step && cfg.keyer_enable) begin
      next_is_dah    <= next_is_dah_next;
      tone_left      <= tone_left_next;
      busy_left      <= busy_left_next;
      letter_left    <= letter_left_next;
      word_left      <= word_left_next;
      word_done      <= word_done_next;
      elements_held  <= elements_held_next;
      elements_count <= elements_count_next;
      tone_state     <= tone_state_next;
    end
  end

endmodule

/* sv/iambic_keyer_with_debounce.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   in_data   (in_t)
// out       output     out_valid/out_stall out_data  (out_t)
// config    input      APB psel/penable    paddr/pwdata, prdata
//
// One tick enters an input register, is processed in one combinational pass
// (paddle windows and keyer timers), and lands in the output register.
// A new tick is accepted every cycle while the output register is empty or
// being taken, so throughput is one tick per cycle.
// Reset is synchronous and active high; it clears all state but the input and output data registers.
// A stall on the output holds the result and backs up into in_stall.
`include "iambic_keyer_with_debounce_defines.svh"

module iambic_keyer_with_debounce
  import ikd_pkg::*;
#(
  parameter int unsigned WINDOW_LEN   = 16,
  parameter int unsigned MAX_ELEMENTS = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  in_t  in_reg;
  logic in_reg_valid;
  logic advance;
  logic step;
  logic dit_p;
  logic dah_p;
  out_t result;

  ikd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: the held tick moves on when the output register is free.
  assign advance  = !out_valid || !out_stall;
  assign step     = in_reg_valid && advance;
  assign in_stall = in_reg_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg <= in_data;
    end
  end

  // Paddle debounce windows.
  ikd_filter #(.WINDOW_LEN(WINDOW_LEN)) u_dit_filter (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .raw_level (in_reg.raw_dit_level),
    .threshold (cfg.press_threshold),
    .pressed   (dit_p)
  );

  ikd_filter #(.WINDOW_LEN(WINDOW_LEN)) u_dah_filter (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .raw_level (in_reg.raw_dah_level),
    .threshold (cfg.press_threshold),
    .pressed   (dah_p)
  );

  // Keyer timing and letter assembly.
  ikd_keyer #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_keyer (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .cfg         (cfg),
    .dit_pressed (dit_p),
    .dah_pressed (dah_p),
    .result      (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

  // Checks on the internal flow and on the result encoding.
  `IKD_ASSERT_NEXT(a_tick_moves, in_reg_valid && !out_stall, out_valid, "held tick did not advance")
  `IKD_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output stall")
  `IKD_ASSERT_SAME(a_no_code_without_letter, out_valid && (out_data.event_kind != EV_LETTER), (out_data.code_pattern == 6'd0) && (out_data.code_length == 3'd0), "code fields set without a letter")

endmodule

/* bench/keyer_bench_pkg.sv */
`timescale 1ns / 1ps

package keyer_bench_pkg;

  // Configuration registers in port order; the byte address is four times the index.
  typedef enum int {
    REG_DIT_TICKS = 0,
    REG_DAH_TICKS,
    REG_ELEM_GAP,
    REG_LETTER_GAP,
    REG_WORD_GAP,
    REG_THRESHOLD,
    REG_KEYER_EN
  } keyer_reg_e;

  localparam int NUM_REGS = 7;

endpackage

/* bench/keyer_check.sv */
`timescale 1ns / 1ps

module keyer_check
  import ikd_pkg::*;
  import keyer_bench_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          mismatches,
  output int          ticks_owed,
  output int          ticks_done,
  output int          letters_seen,
  output int          words_seen
);

  localparam int WIN = 16;
  localparam int MAX_ELEMENTS = 6;

  // Shadow of the register file as the keyer should see it.
  cfg_t regs;

  // Paddle filter state.
  logic [WIN-1:0] dit_win;
  logic [WIN-1:0] dah_win;
  logic [6:0]     dit_sum;
  logic [6:0]     dah_sum;
  logic [5:0]     win_slot;

  // Keyer timing and letter assembly state.
  logic           alt_dah;
  logic [11:0]    tone_cnt;
  logic [12:0]    busy_cnt;
  logic [11:0]    letter_cnt;
  logic [13:0]    word_cnt;
  logic           word_sent;
  logic [5:0]     held_pat;
  logic [2:0]     held_len;
  logic           tone_q;

  // Results owed by the block, one per accepted tick, oldest first.
  out_t owed_q[$];

  task automatic clear_keyer();
    regs.dit_ticks         = RST_DIT_TICKS;
    regs.dah_ticks         = RST_DAH_TICKS;
    regs.element_gap_ticks = RST_ELEM_GAP;
    regs.letter_gap_ticks  = RST_LETTER_GAP;
    regs.word_gap_ticks    = RST_WORD_GAP;
    regs.press_threshold   = RST_THRESHOLD;
    regs.keyer_enable      = RST_KEYER_EN;
    dit_win    = '0;
    dah_win    = '0;
    dit_sum    = '0;
    dah_sum    = '0;
    win_slot   = '0;
    alt_dah    = 1'b0;
    tone_cnt   = '0;
    busy_cnt   = STARTUP_BUSY;
    letter_cnt = '0;
    word_cnt   = '0;
    word_sent  = 1'b0;
    held_pat   = '0;
    held_len   = '0;
    tone_q     = 1'b0;
  endtask

  // Begin a dit or dah; a full letter is dropped and a fresh one started.
  task automatic begin_element(input logic is_dah);
    if (held_len >= MAX_ELEMENTS) begin
      held_len = '0;
      held_pat = '0;
    end
    tone_cnt = is_dah ? regs.dah_ticks : 12'(regs.dit_ticks);
    if (is_dah && held_len < PATTERN_BITS) held_pat = held_pat | (6'd1 << held_len);
    held_len   = held_len + 3'd1;
    letter_cnt = regs.letter_gap_ticks;
    busy_cnt   = 13'(regs.element_gap_ticks) + 13'(tone_cnt);
  endtask

  // Advance the filter and the keyer by one millisecond tick.
  task automatic run_keyer_tick(input in_t t, output out_t r);
    int   slot;
    logic dit_down;
    logic dah_down;
    slot = int'(win_slot) % WIN;
    dit_sum = dit_sum - 7'(dit_win[slot]) + 7'(t.raw_dit_level);
    dah_sum = dah_sum - 7'(dah_win[slot]) + 7'(t.raw_dah_level);
    dit_win[slot] = t.raw_dit_level;
    dah_win[slot] = t.raw_dah_level;
    win_slot = 6'((slot + 1) % WIN);
    dit_down = dit_sum < regs.press_threshold;
    dah_down = dah_sum < regs.press_threshold;
    r = '0;
    r.event_kind = EV_NONE;

    if (regs.keyer_enable) begin
      // Start an element only once the previous one and its gap are over.
      if (busy_cnt == 0) begin
        if (dit_down && dah_down) begin
          begin_element(alt_dah);
          alt_dah = ~alt_dah;
        end else if (dit_down) begin
          begin_element(1'b0);
          alt_dah = 1'b1;
        end else if (dah_down) begin
          begin_element(1'b1);
          alt_dah = 1'b0;
        end
      end
      // Time the tone, then the letter gap, then the word gap.
      if (busy_cnt != 0) begin
        busy_cnt = busy_cnt - 13'd1;
        if (tone_cnt != 0) begin
          tone_q   = 1'b1;
          tone_cnt = tone_cnt - 12'd1;
        end else begin
          tone_q = 1'b0;
        end
      end else if (letter_cnt != 0) begin
        letter_cnt = letter_cnt - 12'd1;
      end else if (held_len != 0) begin
        r.event_kind   = EV_LETTER;
        r.code_pattern = held_pat;
        r.code_length  = held_len;
        held_pat  = '0;
        held_len  = '0;
        word_cnt  = 14'(regs.word_gap_ticks);
        word_sent = 1'b0;
      end else if (word_cnt != 0) begin
        word_cnt = word_cnt - 14'd1;
      end else if (!word_sent) begin
        r.event_kind = EV_WORD;
        word_sent    = 1'b1;
      end
    end

    r.tone_on     = tone_q;
    r.dit_pressed = dit_down;
    r.dah_pressed = dah_down;
  endtask

  function automatic logic [31:0] reg_value(input keyer_reg_e idx);
    case (idx)
      REG_DIT_TICKS:  return 32'(regs.dit_ticks);
      REG_DAH_TICKS:  return 32'(regs.dah_ticks);
      REG_ELEM_GAP:   return 32'(regs.element_gap_ticks);
      REG_LETTER_GAP: return 32'(regs.letter_gap_ticks);
      REG_WORD_GAP:   return 32'(regs.word_gap_ticks);
      REG_THRESHOLD:  return 32'(regs.press_threshold);
      REG_KEYER_EN:   return 32'(regs.keyer_enable);
      default:        return '0;
    endcase
  endfunction

  task automatic store_reg(input keyer_reg_e idx, input logic [31:0] data);
    case (idx)
      REG_DIT_TICKS:  regs.dit_ticks         = data[9:0];
      REG_DAH_TICKS:  regs.dah_ticks         = data[11:0];
      REG_ELEM_GAP:   regs.element_gap_ticks = data[9:0];
      REG_LETTER_GAP: regs.letter_gap_ticks  = data[11:0];
      REG_WORD_GAP:   regs.word_gap_ticks    = data[12:0];
      REG_THRESHOLD:  regs.press_threshold   = data[6:0];
      REG_KEYER_EN:   regs.keyer_enable      = data[0];
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at result %0d, %s: got %0h, want %0h", ticks_done, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Follow every transaction on the three ports at the clock edge.
  always @(posedge clk) begin
    out_t       want;
    keyer_reg_e idx;
    if (rst) begin
      clear_keyer();
      owed_q.delete();
      mismatches   = 0;
      ticks_done   = 0;
      letters_seen = 0;
      words_seen   = 0;
      ticks_owed  <= 0;
    end else begin
      // Register writes update the shadow; reads must return it.
      if (psel && penable && pready) begin
        idx = keyer_reg_e'(int'(paddr[4:2]));
        if (pwrite) store_reg(idx, pwdata);
        else check_field("register read", prdata, reg_value(idx));
      end

      // A result leaving the block is matched with the oldest owed one.
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          report_mismatch("result with no tick outstanding", 32'(out_data), '0);
        end else begin
          want = owed_q.pop_front();
          check_field("tone_on", 32'(out_data.tone_on), 32'(want.tone_on));
          check_field("dit_pressed", 32'(out_data.dit_pressed), 32'(want.dit_pressed));
          check_field("dah_pressed", 32'(out_data.dah_pressed), 32'(want.dah_pressed));
          check_field("event_kind", 32'(out_data.event_kind), 32'(want.event_kind));
          check_field("code_pattern", 32'(out_data.code_pattern), 32'(want.code_pattern));
          check_field("code_length", 32'(out_data.code_length), 32'(want.code_length));
          if (want.event_kind == EV_LETTER) letters_seen++;
          if (want.event_kind == EV_WORD) words_seen++;
        end
        ticks_done++;
      end

      // Each accepted tick owes exactly one result.
      if (in_valid && !in_stall) begin
        run_keyer_tick(in_data, want);
        owed_q.push_back(want);
      end

      ticks_owed <= owed_q.size();
    end
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
  import ikd_pkg::*;
  import keyer_bench_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int PHASES      = 12;
  localparam int PHASE_TICKS = 110;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_t         in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [4:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int ticks_owed;
  int ticks_done;
  int letters_seen;
  int words_seen;
  int quiet_cycles = 0;
  idle_mode_e idle_mode = IDLE_NONE;

  iambic_keyer_with_debounce uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  keyer_check u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .mismatches(mismatches), .ticks_owed(ticks_owed), .ticks_done(ticks_done),
    .letters_seen(letters_seen), .words_seen(words_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit coin(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  // The receiver stalls at random according to the current idle pattern.
  always @(posedge clk) begin
    case (idle_mode)
      IDLE_RECEIVER: out_stall <= coin(86);
      IDLE_BOTH:     out_stall <= coin(36);
      default:       out_stall <= 1'b0;
    endcase
  end

  // Give up when no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one tick, idling first when the sender pattern says so.
  task automatic send_tick(input logic dit_lvl, input logic dah_lvl);
    in_t t;
    t.raw_dit_level = dit_lvl;
    t.raw_dah_level = dah_lvl;
    while ((idle_mode == IDLE_SENDER && coin(86)) || (idle_mode == IDLE_BOTH && coin(36))) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering ticks and wait until every owed result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ticks_owed != 0) @(posedge clk);
  endtask

  // One APB access: setup, access until ready, then idle.
  task automatic apb_access(input keyer_reg_e idx, input logic wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= 5'(int'(idx) * 4);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int reg_width(input keyer_reg_e idx);
    case (idx)
      REG_DIT_TICKS, REG_ELEM_GAP:   return 10;
      REG_DAH_TICKS, REG_LETTER_GAP: return 12;
      REG_WORD_GAP:                  return 13;
      REG_THRESHOLD:                 return 7;
      default:                       return 1;
    endcase
  endfunction

  // Half of the writes carry junk above the field to exercise masking.
  task automatic write_reg(input keyer_reg_e idx, input int value);
    logic [31:0] data;
    logic [31:0] mask;
    mask = (32'd1 << reg_width(idx)) - 32'd1;
    data = 32'(value) & mask;
    if (coin(50)) data = data | ($urandom & ~mask);
    apb_access(idx, 1'b1, data);
  endtask

  task automatic read_all();
    for (int i = 0; i < NUM_REGS; i++) apb_access(keyer_reg_e'(i), 1'b0, '0);
  endtask

  task automatic program_keyer(input int dit, input int dah, input int gap, input int letter,
                               input int word, input int thr, input int en);
    write_reg(REG_DIT_TICKS, dit);
    write_reg(REG_DAH_TICKS, dah);
    write_reg(REG_ELEM_GAP, gap);
    write_reg(REG_LETTER_GAP, letter);
    write_reg(REG_WORD_GAP, word);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_KEYER_EN, en);
    read_all();
  endtask

  // Mostly deliberate paddle gestures with some contact bounce, plus raw noise.
  task automatic play_keying(input int budget);
    int   sent;
    int   run;
    logic dit_lvl;
    logic dah_lvl;
    sent = 0;
    while (sent < budget) begin
      if (coin(80)) begin
        case ($urandom_range(3))
          0:       begin dit_lvl = 1'b0; dah_lvl = 1'b1; end
          1:       begin dit_lvl = 1'b1; dah_lvl = 1'b0; end
          2:       begin dit_lvl = 1'b0; dah_lvl = 1'b0; end
          default: begin dit_lvl = 1'b1; dah_lvl = 1'b1; end
        endcase
        run = (dit_lvl && dah_lvl) ? $urandom_range(60, 1) : $urandom_range(40, 1);
        repeat (run) begin
          send_tick(dit_lvl ^ coin(5), dah_lvl ^ coin(5));
          sent++;
        end
      end else begin
        run = $urandom_range(20, 1);
        repeat (run) begin
          send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers must read back their reset values.
    read_all();

    // Paddles released while the start-up delay runs out; a word space follows it.
    repeat (110) send_tick(1'b1, 1'b1);
    drain();

    // A threshold above the window length presses both paddles: squeeze until the
    // letter overflows, with no gaps so the tone stays on into idle.
    program_keyer(1, 2, 0, 0, 0, 64, 1);
    repeat (10) send_tick(1'b1, 1'b1);
    drain();

    // A zero threshold releases everything: the letter goes out, then a word space.
    write_reg(REG_THRESHOLD, 0);
    repeat (4) send_tick(1'b0, 1'b0);
    drain();

    // Frozen keyer with the filter still running, then silent zero-length dits.
    program_keyer(0, 3, 1, 2, 3, 17, 0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    drain();
    write_reg(REG_KEYER_EN, 1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    drain();

    // Random keying under short timings; the last phase uses every maximum.
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1)
        program_keyer(1023, 4095, 1023, 4095, 8191, 127, 1);
      else
        program_keyer($urandom_range(4, 1), $urandom_range(8, 1), $urandom_range(3),
                      $urandom_range(6), $urandom_range(15), $urandom_range(17, 1),
                      (ph == 6) ? 0 : 1);
      idle_mode <= idle_mode_e'(ph % 4);
      play_keying(PHASE_TICKS);
      drain();
    end

    idle_mode <= IDLE_NONE;
    repeat (10) @(posedge clk);
    $display("Checked %0d ticks over %0d register settings with all four idle patterns.",
             ticks_done, PHASES + 4);
    $display("Decoded %0d letters and %0d word spaces; %0d mismatches.",
             letters_seen, words_seen, mismatches);
    if (mismatches == 0 && ticks_owed == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/ikd_pkg.sv
sv/ikd_regs.sv
sv/ikd_filter.sv
sv/ikd_keyer.sv
sv/iambic_keyer_with_debounce.sv
bench/keyer_bench_pkg.sv
bench/keyer_check.sv
bench/tb.sv
